// ----- rtl/core/i2cm_pkg.sv -----
package i2cm_pkg;

   // command codes carried in the kind field
   localparam int unsigned KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_START     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STOP      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ_ACK  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ_NACK = 3'd5;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_LIMIT   = 1'd1;

   localparam int unsigned HALF_W  = 16;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BITCNT_W = 4;

   localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET = 16'd50;
   localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET   = 8'd250;

   // bit count value reached after the last bit of a byte
   localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

   typedef logic [KIND_W-1:0] kind_type;

endpackage

// ----- rtl/core/i2c_master_byte_engine.sv -----
// channel | ports                                  | transfer
// --------+----------------------------------------+-----------------------------------------
// req     | req_valid, req_stall, kind/tx/sda_in   | one bus tick, optionally with a command
// rsp     | rsp_valid, rsp_stall, pin and status   | pin levels and status after that tick
// csr     | csr_write_enable, csr_index, data      | register write, taken at once
//
// one tick is processed per clock cycle: the sequencer state is updated at the edge the
// request transfer happens and the state registers themselves are the response payload
// reset is synchronous; it leaves scl high, sda released and no response pending
// a request is taken while the response register is empty or is drained in the same cycle,
// so back-to-back ticks flow at one per cycle when rsp_stall stays low
// while a response is held by rsp_stall the request side is stalled
module i2c_master_byte_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  i2cm_pkg::kind_type                   req_kind,
   input  logic [i2cm_pkg::BYTE_W-1:0]          req_tx_byte,
   input  logic                                 req_sda_in,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_scl_level,
   output logic                                 rsp_sda_level,
   output logic                                 rsp_sda_drive,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic [i2cm_pkg::BYTE_W-1:0]          rsp_rx_byte,
   output logic                                 rsp_no_ack,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [i2cm_pkg::HALF_W-1:0]          csr_write_data
);
   import i2cm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST1,
      PH_ST2,
      PH_SP1,
      PH_SP2,
      PH_SP3,
      PH_WR_HI,
      PH_WR_LO,
      PH_ACK_POLL,
      PH_RD_HI,
      PH_RD_LO,
      PH_AK_SDA,
      PH_AK_SCLH,
      PH_AK_END
   } phase_type;

   // configuration registers
   logic [HALF_W-1:0]   half_period_ff;
   logic [LIMIT_W-1:0]  ack_limit_ff;

   // sequencer state, doubles as the response payload
   phase_type           phase_ff, phase_in;
   kind_type            command_ff, command_in;
   logic [BITCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [HALF_W-1:0]   wait_count_ff, wait_count_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [LIMIT_W-1:0]  poll_count_ff, poll_count_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic                drive_ff, drive_in;
   logic [BYTE_W-1:0]   rx_ff, rx_in;
   logic                no_ack_ff, no_ack_in;
   logic                done_ff, done_in;

   logic                rsp_valid_ff;
   logic                req_take;
   logic [HALF_W-1:0]   arm_wait;
   logic [BITCNT_W-1:0] bit_count_inc;

   // a pending response blocks new ticks until it drains
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // reload for the delay counter, a zero half period acts as one tick
   assign arm_wait      = (half_period_ff == '0) ? '0 : half_period_ff - 1'b1;
   assign bit_count_inc = bit_count_ff + 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      command_in    = command_ff;
      bit_count_in  = bit_count_ff;
      wait_count_in = wait_count_ff;
      shift_in      = shift_ff;
      poll_count_in = poll_count_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      rx_in         = rx_ff;
      no_ack_in     = no_ack_ff;
      done_in       = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // new command, only looked at while idle
         command_in = req_kind;
         case (req_kind)
            KIND_START: begin
               drive_in      = 1'b1;
               scl_in        = 1'b1;
               sda_in        = 1'b1;
               phase_in      = PH_ST1;
               wait_count_in = arm_wait;
            end
            KIND_STOP: begin
               drive_in      = 1'b1;
               scl_in        = 1'b0;
               sda_in        = 1'b0;
               phase_in      = PH_SP1;
               wait_count_in = arm_wait;
            end
            KIND_WRITE: begin
               // msb goes out now, the rest shifts up
               sda_in        = req_tx_byte[BYTE_W-1];
               shift_in      = {req_tx_byte[BYTE_W-2:0], 1'b0};
               bit_count_in  = '0;
               drive_in      = 1'b1;
               scl_in        = 1'b0;
               phase_in      = PH_WR_HI;
               wait_count_in = arm_wait;
            end
            KIND_READ_ACK, KIND_READ_NACK: begin
               shift_in      = '0;
               bit_count_in  = '0;
               drive_in      = 1'b0;
               scl_in        = 1'b0;
               phase_in      = PH_RD_HI;
               wait_count_in = arm_wait;
            end
            default: begin
               // plain tick and unused codes
               command_in = KIND_TICK;
            end
         endcase
      end else if (wait_count_ff != '0) begin
         wait_count_in = wait_count_ff - 1'b1;
      end else begin
         case (phase_ff)
            PH_ST1: begin
               sda_in        = 1'b0;
               phase_in      = PH_ST2;
               wait_count_in = arm_wait;
            end
            PH_ST2: begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_SP1: begin
               scl_in        = 1'b1;
               phase_in      = PH_SP2;
               wait_count_in = arm_wait;
            end
            PH_SP2: begin
               sda_in        = 1'b1;
               phase_in      = PH_SP3;
               wait_count_in = arm_wait;
            end
            PH_SP3: begin
               drive_in = 1'b0;
               // a stop that closes a timed-out write flags it
               if (command_ff == KIND_WRITE) begin
                  no_ack_in = 1'b1;
               end
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_WR_HI: begin
               scl_in        = 1'b1;
               phase_in      = PH_WR_LO;
               wait_count_in = arm_wait;
            end
            PH_WR_LO: begin
               scl_in       = 1'b0;
               bit_count_in = bit_count_inc;
               if (bit_count_inc < BITS_PER_BYTE) begin
                  sda_in        = shift_ff[BYTE_W-1];
                  shift_in      = {shift_ff[BYTE_W-2:0], 1'b0};
                  phase_in      = PH_WR_HI;
                  wait_count_in = arm_wait;
               end else begin
                  // release sda and clock the ack bit
                  drive_in      = 1'b0;
                  scl_in        = 1'b1;
                  poll_count_in = '0;
                  phase_in      = PH_ACK_POLL;
                  wait_count_in = arm_wait;
               end
            end
            PH_ACK_POLL: begin
               if (!req_sda_in) begin
                  scl_in    = 1'b0;
                  no_ack_in = 1'b0;
                  phase_in  = PH_IDLE;
                  done_in   = 1'b1;
               end else if (poll_count_ff >= ack_limit_ff) begin
                  // timeout, run a stop
                  drive_in      = 1'b1;
                  scl_in        = 1'b0;
                  sda_in        = 1'b0;
                  phase_in      = PH_SP1;
                  wait_count_in = arm_wait;
               end else begin
                  poll_count_in = poll_count_ff + 1'b1;
               end
            end
            PH_RD_HI: begin
               scl_in        = 1'b1;
               shift_in      = {shift_ff[BYTE_W-2:0], req_sda_in};
               bit_count_in  = bit_count_inc;
               phase_in      = PH_RD_LO;
               wait_count_in = arm_wait;
            end
            PH_RD_LO: begin
               scl_in = 1'b0;
               if (bit_count_ff < BITS_PER_BYTE) begin
                  phase_in = PH_RD_HI;
               end else begin
                  drive_in = 1'b1;
                  phase_in = PH_AK_SDA;
               end
               wait_count_in = arm_wait;
            end
            PH_AK_SDA: begin
               sda_in        = (command_ff == KIND_READ_NACK);
               phase_in      = PH_AK_SCLH;
               wait_count_in = arm_wait;
            end
            PH_AK_SCLH: begin
               scl_in        = 1'b1;
               phase_in      = PH_AK_END;
               wait_count_in = arm_wait;
            end
            PH_AK_END: begin
               scl_in   = 1'b0;
               rx_in    = shift_ff;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         ack_limit_ff   <= ACK_LIMIT_RESET;
         phase_ff       <= PH_IDLE;
         command_ff     <= KIND_TICK;
         bit_count_ff   <= '0;
         wait_count_ff  <= '0;
         shift_ff       <= '0;
         poll_count_ff  <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         drive_ff       <= 1'b0;
         rx_ff          <= '0;
         no_ack_ff      <= 1'b0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HALF_PERIOD: half_period_ff <= csr_write_data;
               CSR_ACK_LIMIT:   ack_limit_ff   <= csr_write_data[LIMIT_W-1:0];
               default: ;
            endcase
         end

         // state only moves when a tick is taken, so a stalled response holds
         if (req_take) begin
            phase_ff      <= phase_in;
            command_ff    <= command_in;
            bit_count_ff  <= bit_count_in;
            wait_count_ff <= wait_count_in;
            shift_ff      <= shift_in;
            poll_count_ff <= poll_count_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            drive_ff      <= drive_in;
            rx_ff         <= rx_in;
            no_ack_ff     <= no_ack_in;
            done_ff       <= done_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = drive_ff;
   assign rsp_busy_res  = (phase_ff != PH_IDLE);
   assign rsp_done_res  = done_ff;
   assign rsp_rx_byte   = rx_ff;
   assign rsp_no_ack    = no_ack_ff;

endmodule
